### hdl/bm_pkg.sv
package bm_pkg;

   localparam int PatternMaxDefault  = 64;
   localparam int TextMaxDefault     = 512;
   localparam int AlphabetDefault    = 256;
   localparam int ColumnWidth        = 9;

   localparam logic ActionPattern = 1'b0;
   localparam logic ActionText    = 1'b1;

   typedef struct packed {
      logic       action;
      logic [7:0] byte_value;
      logic       is_last;
      logic       is_empty;
   } req_payload_type;

   typedef struct packed {
      logic                   found;
      logic [ColumnWidth-1:0] match_column;
      logic                   overflow;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BC_CLEAR,
      ST_BC_FILL,
      ST_BC_FILL_W,
      ST_GS_CLEAR,
      ST_GS_INIT,
      ST_GS_OUTER,
      ST_GS_RDJ,
      ST_GS_CMP,
      ST_GS_RDGS,
      ST_GS_UPD,
      ST_GS_STEP,
      ST_GS2_START,
      ST_GS2_RD,
      ST_GS2_UPD,
      ST_SR_START,
      ST_SR_RD,
      ST_SR_CMP,
      ST_SR_RDTAB,
      ST_SR_SHIFT,
      ST_DONE
   } state_type;

endpackage

### hdl/bm_stream_if.sv
interface bm_req_if;
   logic                     valid;
   logic                     ready;
   bm_pkg::req_payload_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bm_rsp_if;
   logic                     valid;
   logic                     ready;
   bm_pkg::rsp_payload_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hdl/boyer_moore_first_match.sv
// Boyer-Moore first-match search. Pattern bytes and then text bytes arrive one
// item each; items can follow back to back while the block is idle. After reset
// the block first runs its table build on an empty pattern and is not ready
// meanwhile. The last pattern byte or an empty pattern item (or the last text
// byte while a pattern is still open) starts the table build: a sweep to clear
// the bad-character table, a read and a write per pattern byte to fill it, a
// sweep to clear the good-suffix tables, a setup step, the border pass, then
// the final shift pass. The last text byte or an empty text item then runs the
// search: a setup step, a read and a compare per compared byte, a table read
// and a shift step per mismatch, a final window check and the handover of the
// result (which waits while an earlier result still waits). All of it goes
// through the single-port table memories; the block takes no item until the
// result has been handed to the output register. One result follows each text
// line: found, zero-based column and an overflow flag that is set when pattern
// or text ran past its store.
module boyer_moore_first_match #(
   parameter int PATTERN_MAX   = bm_pkg::PatternMaxDefault,
   parameter int TEXT_MAX      = bm_pkg::TextMaxDefault,
   parameter int ALPHABET_SIZE = bm_pkg::AlphabetDefault
) (
   input  logic      clock,
   input  logic      reset,
   bm_req_if.sink    req,
   bm_rsp_if.source  rsp
);

   localparam int PW = $clog2(PATTERN_MAX + 2) + 1;   // signed index width
   localparam int TW = $clog2(TEXT_MAX + 1) + 2;      // signed text position
   localparam int PA = $clog2(PATTERN_MAX);
   localparam int TA = $clog2(TEXT_MAX);
   localparam int GA = $clog2(PATTERN_MAX + 2);
   localparam int BA = $clog2(ALPHABET_SIZE);
   localparam int PA1 = (PA > 0) ? PA : 1;
   localparam int TA1 = (TA > 0) ? TA : 1;
   localparam int KW = ((BA > GA) ? BA : GA) + 1;     // sweep counter width

   // fold a byte into the bad-character table range
   function automatic logic [BA-1:0] fold_byte(input logic [7:0] c);
      logic [8:0] w;
      w = {1'b0, c};
      if (w >= 9'(ALPHABET_SIZE)) w = w - 9'(ALPHABET_SIZE);
      return w[BA-1:0];
   endfunction

   // memories
   logic [7:0]          pat_mem [PATTERN_MAX];
   logic [7:0]          txt_mem [TEXT_MAX];
   logic signed [PW-1:0] bc_mem [ALPHABET_SIZE];
   logic signed [PW-1:0] sb_mem [PATTERN_MAX + 2];
   logic signed [PW-1:0] gs_mem [PATTERN_MAX + 2];

   bm_pkg::state_type state_ff, state_in;

   logic [PW-1:0] plen_ff, plen_in;
   logic [TW-1:0] tlen_ff, tlen_in;
   logic pat_over_ff, pat_over_in, txt_over_ff, txt_over_in;
   logic pat_open_ff, pat_open_in, txt_open_ff, txt_open_in;
   logic search_ff, search_in;
   logic signed [PW-1:0] i_ff, i_in, j_ff, j_in;
   logic signed [TW-1:0] pos_ff, pos_in;
   logic [KW-1:0] k_ff, k_in;
   logic signed [PW-1:0] tab_ff;
   logic rsp_valid_ff, rsp_valid_in;
   bm_pkg::rsp_payload_type rsp_ff, rsp_in;

   // memory request lines
   logic          pat_we, txt_we, bc_we, sb_we, gs_we;
   logic [PA1-1:0] pat_wa, pat_ra, pat_rb;
   logic [TA1-1:0] txt_wa, txt_ra;
   logic [7:0]    wbyte;
   logic [BA-1:0] bc_a;
   logic [GA-1:0] sb_a, gs_a;
   logic signed [PW-1:0] bc_wd, sb_wd, gs_wd;
   logic [7:0]    pat_qa, pat_qb, txt_q;
   logic signed [PW-1:0] bc_q, sb_q, gs_q;

   always_ff @(posedge clock) begin
      if (pat_we) pat_mem[pat_wa] <= wbyte;
      pat_qa <= pat_mem[pat_ra];
      pat_qb <= pat_mem[pat_rb];
   end
   always_ff @(posedge clock) begin
      if (txt_we) txt_mem[txt_wa] <= wbyte;
      txt_q <= txt_mem[txt_ra];
   end
   always_ff @(posedge clock) begin
      if (bc_we) bc_mem[bc_a] <= bc_wd;
      bc_q <= bc_mem[bc_a];
   end
   always_ff @(posedge clock) begin
      if (sb_we) sb_mem[sb_a] <= sb_wd;
      sb_q <= sb_mem[sb_a];
   end
   always_ff @(posedge clock) begin
      if (gs_we) gs_mem[gs_a] <= gs_wd;
      gs_q <= gs_mem[gs_a];
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bm_pkg::ST_BC_CLEAR;
         plen_ff      <= '0;
         tlen_ff      <= '0;
         pat_over_ff  <= 1'b0;
         txt_over_ff  <= 1'b0;
         pat_open_ff  <= 1'b0;
         txt_open_ff  <= 1'b0;
         search_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         plen_ff      <= plen_in;
         tlen_ff      <= tlen_in;
         pat_over_ff  <= pat_over_in;
         txt_over_ff  <= txt_over_in;
         pat_open_ff  <= pat_open_in;
         txt_open_ff  <= txt_open_in;
         search_ff    <= search_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
      tab_ff <= bc_q;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   logic req_fire;
   bm_pkg::req_payload_type rq;
   logic signed [PW-1:0] m_s;
   logic signed [TW-1:0] sh_gs, sh_bc, sh;
   logic signed [TW-1:0] ij;

   always_comb begin
      rq       = req.payload;
      req.ready = (state_ff == bm_pkg::ST_IDLE);
      req_fire = req.valid && req.ready;
      m_s      = plen_ff;
      state_in = state_ff;
      plen_in  = plen_ff;   tlen_in = tlen_ff;
      pat_over_in = pat_over_ff; txt_over_in = txt_over_ff;
      pat_open_in = pat_open_ff; txt_open_in = txt_open_ff;
      search_in = search_ff;
      i_in = i_ff; j_in = j_ff; pos_in = pos_ff; k_in = k_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pat_we = 1'b0; txt_we = 1'b0; bc_we = 1'b0; sb_we = 1'b0; gs_we = 1'b0;
      wbyte = rq.byte_value;
      pat_wa = plen_ff[PA1-1:0];
      txt_wa = tlen_ff[TA1-1:0];
      pat_ra = '0; pat_rb = '0; txt_ra = '0;
      bc_a = '0; sb_a = '0; gs_a = '0;
      bc_wd = '0; sb_wd = '0; gs_wd = '0;
      ij = TW'(pos_ff) + TW'(j_ff);
      sh_gs = TW'(gs_q);
      sh_bc = TW'(j_ff) - TW'(tab_ff);
      sh = (sh_gs > sh_bc) ? sh_gs : sh_bc;
      if (sh < TW'(1)) sh = TW'(1);

      unique case (state_ff)
         bm_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (rq.action == bm_pkg::ActionPattern) begin
                  if (rq.is_empty || !pat_open_ff) begin
                     plen_in = '0; pat_over_in = 1'b0;
                     pat_wa = '0;
                  end
                  if (!rq.is_empty) begin
                     if ((rq.is_empty || !pat_open_ff) || plen_ff < PW'(PATTERN_MAX)) begin
                        pat_we = 1'b1;
                        plen_in = ((rq.is_empty || !pat_open_ff) ? '0 : plen_ff) + 1'b1;
                     end else begin
                        pat_over_in = 1'b1;
                     end
                  end
                  pat_open_in = 1'b1;
                  if (rq.is_empty || rq.is_last) begin
                     pat_open_in = 1'b0;
                     search_in = 1'b0;
                     k_in = '0;
                     state_in = bm_pkg::ST_BC_CLEAR;
                  end
               end else begin
                  if (rq.is_empty || !txt_open_ff) begin
                     tlen_in = '0; txt_over_in = 1'b0;
                     txt_wa = '0;
                  end
                  if (!rq.is_empty) begin
                     if ((rq.is_empty || !txt_open_ff) || tlen_ff < TW'(TEXT_MAX)) begin
                        txt_we = 1'b1;
                        tlen_in = ((rq.is_empty || !txt_open_ff) ? '0 : tlen_ff) + 1'b1;
                     end else begin
                        txt_over_in = 1'b1;
                     end
                  end
                  txt_open_in = 1'b1;
                  if (rq.is_empty || rq.is_last) begin
                     txt_open_in = 1'b0;
                     search_in = 1'b1;
                     k_in = '0;
                     if (pat_open_ff) begin
                        pat_open_in = 1'b0;
                        state_in = bm_pkg::ST_BC_CLEAR;
                     end else begin
                        state_in = bm_pkg::ST_SR_START;
                     end
                  end
               end
            end
         end

         // sweep bad-character table to -1
         bm_pkg::ST_BC_CLEAR: begin
            bc_a = k_ff[BA-1:0]; bc_we = 1'b1; bc_wd = -PW'(1);
            k_in = k_ff + 1'b1;
            if (k_ff == KW'(ALPHABET_SIZE - 1)) begin
               k_in = '0;
               state_in = (plen_ff == '0) ? bm_pkg::ST_GS_CLEAR : bm_pkg::ST_BC_FILL;
            end
         end
         // read pattern byte k
         bm_pkg::ST_BC_FILL: begin
            pat_ra = k_ff[PA1-1:0];
            state_in = bm_pkg::ST_BC_FILL_W;
         end
         bm_pkg::ST_BC_FILL_W: begin
            bc_a = fold_byte(pat_qa); bc_we = 1'b1; bc_wd = PW'(k_ff);
            k_in = k_ff + 1'b1;
            state_in = bm_pkg::ST_BC_FILL;
            if (PW'(k_ff) + 1'b1 == plen_ff) begin
               k_in = '0;
               state_in = bm_pkg::ST_GS_CLEAR;
            end
         end
         // clear good-suffix and border tables
         bm_pkg::ST_GS_CLEAR: begin
            sb_a = k_ff[GA-1:0]; gs_a = k_ff[GA-1:0];
            sb_we = 1'b1; gs_we = 1'b1;
            k_in = k_ff + 1'b1;
            if (k_ff == KW'(PATTERN_MAX + 1)) begin
               state_in = bm_pkg::ST_GS_INIT;
            end
         end
         bm_pkg::ST_GS_INIT: begin
            i_in = m_s; j_in = m_s + 1'b1;
            sb_a = GA'(m_s); sb_we = 1'b1; sb_wd = m_s + 1'b1;
            state_in = bm_pkg::ST_GS_OUTER;
         end
         // outer loop: while i > 0
         bm_pkg::ST_GS_OUTER: begin
            if (i_ff > 0) begin
               state_in = bm_pkg::ST_GS_RDJ;
            end else begin
               state_in = bm_pkg::ST_GS2_START;
            end
         end
         bm_pkg::ST_GS_RDJ: begin
            if (j_ff <= m_s) begin
               pat_ra = PA1'(i_ff - 1'b1); pat_rb = PA1'(j_ff - 1'b1);
               state_in = bm_pkg::ST_GS_CMP;
            end else begin
               state_in = bm_pkg::ST_GS_STEP;
            end
         end
         bm_pkg::ST_GS_CMP: begin
            gs_a = GA'(j_ff);
            sb_a = GA'(j_ff);
            state_in = (pat_qa != pat_qb) ? bm_pkg::ST_GS_RDGS : bm_pkg::ST_GS_STEP;
         end
         // keep entry j on the read ports for the update
         bm_pkg::ST_GS_RDGS: begin
            gs_a = GA'(j_ff);
            sb_a = GA'(j_ff);
            state_in = bm_pkg::ST_GS_UPD;
         end
         bm_pkg::ST_GS_UPD: begin
            gs_a = GA'(j_ff);
            if (gs_q == '0) begin
               gs_we = 1'b1; gs_wd = j_ff - i_ff;
            end
            j_in = sb_q;
            state_in = bm_pkg::ST_GS_RDJ;
         end
         bm_pkg::ST_GS_STEP: begin
            i_in = i_ff - 1'b1; j_in = j_ff - 1'b1;
            sb_a = GA'(i_ff - 1'b1); sb_we = 1'b1; sb_wd = j_ff - 1'b1;
            state_in = bm_pkg::ST_GS_OUTER;
         end
         // second pass: fill remaining shifts from borders
         bm_pkg::ST_GS2_START: begin
            sb_a = '0;
            i_in = '0;
            state_in = bm_pkg::ST_GS2_RD;
            k_in = '0;
         end
         bm_pkg::ST_GS2_RD: begin
            if (k_ff == '0) j_in = sb_q;
            k_in = KW'(1);
            gs_a = GA'(i_ff);
            sb_a = GA'((k_ff == '0) ? sb_q : j_ff);
            state_in = bm_pkg::ST_GS2_UPD;
         end
         bm_pkg::ST_GS2_UPD: begin
            gs_a = GA'(i_ff);
            if (gs_q == '0) begin
               gs_we = 1'b1; gs_wd = j_ff;
            end
            if (i_ff == j_ff && j_ff >= 0 && j_ff <= m_s + 1'b1) j_in = sb_q;
            i_in = i_ff + 1'b1;
            if (i_ff == m_s) begin
               state_in = search_ff ? bm_pkg::ST_SR_START : bm_pkg::ST_IDLE;
            end else begin
               state_in = bm_pkg::ST_GS2_RD;
            end
         end
         // search
         bm_pkg::ST_SR_START: begin
            pos_in = '0;
            j_in = m_s - 1'b1;
            state_in = bm_pkg::ST_SR_RD;
         end
         bm_pkg::ST_SR_RD: begin
            if (pos_ff + TW'(m_s) > TW'(tlen_ff) || j_ff < 0) begin
               state_in = bm_pkg::ST_DONE;
            end else begin
               pat_ra = PA1'(j_ff); txt_ra = TA1'(ij);
               state_in = bm_pkg::ST_SR_CMP;
            end
         end
         bm_pkg::ST_SR_CMP: begin
            if (pat_qa == txt_q) begin
               j_in = j_ff - 1'b1;
               state_in = bm_pkg::ST_SR_RD;
            end else begin
               bc_a = fold_byte(txt_q);
               gs_a = GA'(j_ff + 1'b1);
               state_in = bm_pkg::ST_SR_RDTAB;
            end
         end
         bm_pkg::ST_SR_RDTAB: begin
            gs_a = GA'(j_ff + 1'b1);
            state_in = bm_pkg::ST_SR_SHIFT;
         end
         bm_pkg::ST_SR_SHIFT: begin
            pos_in = pos_ff + sh;
            j_in = m_s - 1'b1;
            state_in = bm_pkg::ST_SR_RD;
         end
         // hand the result over once the output register is free;
         // a negative j means every pattern byte matched
         bm_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_in.found = (j_ff < 0);
               rsp_in.match_column = (j_ff < 0) ? pos_ff[bm_pkg::ColumnWidth-1:0] : '0;
               rsp_in.overflow = pat_over_ff || txt_over_ff;
               rsp_valid_in = 1'b1;
               state_in = bm_pkg::ST_IDLE;
            end
         end
         default: state_in = bm_pkg::ST_IDLE;
      endcase
   end

endmodule

### hdl/bm_checker.sv
module bm_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_found,
   input logic [bm_pkg::ColumnWidth-1:0] rsp_match_column
);

   ap_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   ap_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_match_column))
      else $error("rsp item changed while stalled");

   ap_col_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_column == '0)
      else $error("column nonzero without match");

   ap_busy_after_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result raised while block was idle");

endmodule

bind boyer_moore_first_match bm_checker u_bm_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_found(rsp.payload.found),
   .rsp_match_column(rsp.payload.match_column)
);

### sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PatMax  = 64;
   localparam int TextMax = 512;

   logic clock;
   logic reset;
   bm_req_if req_if ();
   bm_rsp_if rsp_if ();

   boyer_moore_first_match uut (
      .clock(clock),
      .reset(reset),
      .req  (req_if.sink),
      .rsp  (rsp_if.source)
   );

   // predictor state
   byte unsigned pat_bytes[PatMax];
   int           pat_len = 0;
   byte unsigned txt_bytes[TextMax];
   int           txt_len = 0;
   int           bad_char[256] = '{default: -1};
   int           border[PatMax + 2] = '{default: 0};
   int           gs_shift[PatMax + 2] = '{default: 0};
   bit           txt_over = 0;
   bit           pat_over = 0;
   bit           pat_open = 0;
   bit           txt_open = 0;

   bm_pkg::req_payload_type pending_items[$];
   bm_pkg::rsp_payload_type expected_matches[$];
   int errors = 0;
   int mismatches = 0;
   int items_sent = 0;
   int lines_checked = 0;
   int found_count = 0;
   bit hold_off_req = 0;
   bit start_long_hold = 0;
   bit long_hold = 0;
   int stall_cycles;
   int gap_cycles;

   // build bad-character and good-suffix tables
   function automatic void build_tables();
      int m, i, j, k;
      m = pat_len;
      for (k = 0; k < 256; k++) bad_char[k] = -1;
      for (k = 0; k < m; k++) bad_char[pat_bytes[k]] = k;
      for (k = 0; k < PatMax + 2; k++) begin
         gs_shift[k] = 0;
         border[k] = 0;
      end
      i = m;
      j = m + 1;
      border[i] = j;
      while (i > 0) begin
         while (j <= m && pat_bytes[i-1] != pat_bytes[j-1]) begin
            if (gs_shift[j] == 0) gs_shift[j] = j - i;
            j = border[j];
         end
         i--;
         j--;
         border[i] = j;
      end
      j = border[0];
      for (i = 0; i <= m; i++) begin
         if (gs_shift[i] == 0) gs_shift[i] = j;
         if (i == j && j >= 0 && j <= m + 1) j = border[j];
      end
   endfunction

   function automatic int find_first();
      int n, m, i, j, gs, bc, sh;
      n = txt_len;
      m = pat_len;
      i = 0;
      while (i + m <= n) begin
         j = m - 1;
         while (j >= 0 && pat_bytes[j] == txt_bytes[i+j]) j--;
         if (j < 0) return i;
         gs = gs_shift[j+1];
         bc = j - bad_char[txt_bytes[i+j]];
         sh = (gs > bc) ? gs : bc;
         if (sh < 1) sh = 1;
         i += sh;
      end
      return -1;
   endfunction

   // advance predictor on one accepted item
   function automatic void predict_item(bm_pkg::req_payload_type it);
      bm_pkg::rsp_payload_type r;
      int pos;
      if (it.action == bm_pkg::ActionPattern) begin
         if (it.is_empty || !pat_open) begin
            pat_len = 0;
            pat_over = 0;
         end
         if (!it.is_empty) begin
            if (pat_len < PatMax) pat_bytes[pat_len++] = it.byte_value;
            else pat_over = 1;
         end
         pat_open = 1;
         if (it.is_empty || it.is_last) begin
            build_tables();
            pat_open = 0;
         end
         return;
      end
      if (it.is_empty || !txt_open) begin
         txt_len = 0;
         txt_over = 0;
      end
      if (!it.is_empty) begin
         if (txt_len < TextMax) txt_bytes[txt_len++] = it.byte_value;
         else txt_over = 1;
      end
      txt_open = 1;
      if (!(it.is_empty || it.is_last)) return;
      txt_open = 0;
      if (pat_open) begin
         build_tables();
         pat_open = 0;
      end
      pos = find_first();
      r.found = (pos >= 0);
      r.match_column = (pos >= 0) ? pos[bm_pkg::ColumnWidth-1:0] : '0;
      r.overflow = pat_over | txt_over;
      expected_matches.push_back(r);
   endfunction

   function automatic void push_item(bit act, byte unsigned b, bit last, bit empty);
      bm_pkg::req_payload_type it;
      it.action = act;
      it.byte_value = b;
      it.is_last = last;
      it.is_empty = empty;
      pending_items.push_back(it);
   endfunction

   // random byte, sometimes from a small alphabet so matches happen
   function automatic byte unsigned pick_byte(int alpha);
      if (alpha == 0) return 8'($urandom_range(0, 255));
      return 8'("a" + $urandom_range(0, alpha - 1));
   endfunction

   function automatic void push_string(bit act, byte unsigned s[$]);
      if (s.size() == 0) begin
         push_item(act, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
         return;
      end
      foreach (s[k]) push_item(act, s[k], (k == s.size() - 1), 1'b0);
   endfunction

   // random pattern, then text that often embeds it
   function automatic void push_search(int plen, int tlen, int alpha);
      byte unsigned p[$];
      byte unsigned t[$];
      int at;
      for (int k = 0; k < plen; k++) p.push_back(pick_byte(alpha));
      for (int k = 0; k < tlen; k++) t.push_back(pick_byte(alpha));
      if (plen > 0 && tlen >= plen && $urandom_range(0, 2) != 0) begin
         at = $urandom_range(0, tlen - plen);
         for (int k = 0; k < plen; k++) t[at+k] = p[k];
      end
      push_string(bm_pkg::ActionPattern, p);
      push_string(bm_pkg::ActionText, t);
   endfunction

   // clock
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // driver: present queued items with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.payload <= '0;
         gap_cycles <= 0;
      end else if (req_if.valid && !req_if.ready) begin
         // hold the offered item
      end else begin
         if (req_if.valid) begin
            predict_item(req_if.payload);
            items_sent++;
         end
         if (gap_cycles > 0) begin
            gap_cycles <= gap_cycles - 1;
            req_if.valid <= 1'b0;
         end else if (pending_items.size() > 0 && !hold_off_req) begin
            req_if.payload <= pending_items.pop_front();
            req_if.valid <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               gap_cycles <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(0, 2);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted in its own process
   initial begin
      wait (start_long_hold);
      long_hold <= 1'b1;
      repeat (400) @(posedge clock);
      long_hold <= 1'b0;
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      bm_pkg::rsp_payload_type exp_r;
      bm_pkg::rsp_payload_type got;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_cycles <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.payload;
            lines_checked++;
            if (got.found) found_count++;
            if (expected_matches.size() == 0) begin
               errors++;
               if (mismatches++ < 10)
                  $display("unexpected result found=%0d col=%0d ovf=%0d",
                           got.found, got.match_column, got.overflow);
            end else begin
               exp_r = expected_matches.pop_front();
               if (got !== exp_r) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch: exp found=%0d col=%0d ovf=%0d, got %0d %0d %0d",
                              exp_r.found, exp_r.match_column, exp_r.overflow,
                              got.found, got.match_column, got.overflow);
               end
            end
         end
         if (long_hold) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            rsp_if.ready <= 1'b0;
         end else if ($urandom_range(0, 4) == 0) begin
            stall_cycles <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                         : $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      byte unsigned s[$];
      reset = 1;
      repeat (6) @(posedge clock);
      reset <= 0;

      // directed: empty pattern, empty text, extreme bytes
      push_item(bm_pkg::ActionPattern, 8'hff, 1'b1, 1'b1);
      push_item(bm_pkg::ActionText, 8'h00, 1'b0, 1'b1);
      push_item(bm_pkg::ActionPattern, 8'h00, 1'b0, 1'b0);
      push_item(bm_pkg::ActionPattern, 8'hff, 1'b1, 1'b0);
      push_item(bm_pkg::ActionText, 8'h00, 1'b0, 1'b0);
      push_item(bm_pkg::ActionText, 8'hff, 1'b1, 1'b0);
      // text ends while pattern still open
      push_item(bm_pkg::ActionPattern, 8'h80, 1'b0, 1'b0);
      push_item(bm_pkg::ActionText, 8'h80, 1'b1, 1'b0);
      // pattern longer than text
      push_item(bm_pkg::ActionPattern, 8'h41, 1'b0, 1'b0);
      push_item(bm_pkg::ActionPattern, 8'h42, 1'b0, 1'b0);
      push_item(bm_pkg::ActionPattern, 8'h43, 1'b1, 1'b0);
      push_item(bm_pkg::ActionText, 8'h42, 1'b0, 1'b0);
      push_item(bm_pkg::ActionText, 8'h43, 1'b1, 1'b0);
      // empty marker discarding an open text
      push_item(bm_pkg::ActionText, 8'h41, 1'b0, 1'b0);
      push_item(bm_pkg::ActionText, 8'h55, 1'b1, 1'b1);
      // full pattern store with overflow, searched in a short text
      s = {};
      for (int k = 0; k < PatMax + 2; k++) s.push_back(pick_byte(2));
      push_string(bm_pkg::ActionPattern, s);
      s = {};
      for (int k = 0; k < 10; k++) s.push_back(pick_byte(2));
      push_string(bm_pkg::ActionText, s);
      push_search(3, 20, 2);

      // first random stretch
      while (pending_items.size() < 150) push_search($urandom_range(0, 6),
                                                      $urandom_range(0, 24),
                                                      $urandom_range(0, 4));
      // text overflow, then back to short lines
      push_search(4, TextMax + 3, 2);
      wait (pending_items.size() == 0);
      @(posedge clock);
      // long receiver hold-off while the sender keeps offering
      for (int k = 0; k < 12; k++) push_search(2, 3, 2);
      start_long_hold = 1;
      wait (pending_items.size() == 0);
      // sender pause until every result has come
      hold_off_req = 1;
      wait (expected_matches.size() == 0 && !req_if.valid);
      repeat (2) @(posedge clock);
      wait (expected_matches.size() == 0);
      hold_off_req = 0;
      push_search($urandom_range(0, 8), $urandom_range(0, 30), $urandom_range(0, 3));
      push_search(PatMax, PatMax, 2);
      wait (pending_items.size() == 0);
      @(posedge clock);
      wait (!req_if.valid);
      wait (expected_matches.size() == 0);
      repeat (2000) @(posedge clock);
      $display("drove %0d items over short, empty, overflowing and full-store lines",
               items_sent);
      $display("checked %0d results, %0d of them matches, under random and long stalls",
               lines_checked, found_count);
      if (errors == 0 && expected_matches.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #40ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule

### boyer_moore_first_match.f
hdl/bm_pkg.sv
hdl/bm_stream_if.sv
hdl/boyer_moore_first_match.sv
hdl/bm_checker.sv
sim/tb.sv
